// ----- rtl/core/chr_pkg.sv -----
`default_nettype none

package chr_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned LINE_CHARS = 64;

  localparam int unsigned MAX_STORED = LINE_CHARS - 1;
  localparam int unsigned SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LEN_W      = $clog2(LINE_CHARS);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned ADDR_W     = $clog2(ENTRIES * LINE_CHARS);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_OLDER  = 2'd1,
    OP_NEWER  = 2'd2,
    OP_STOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BS_HOLD   = 2'd0,
    BS_NEWEST = 2'd1,
    BS_DEC    = 2'd2,
    BS_INC    = 2'd3
  } bslot_op_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       found;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic      stage_wr;
    logic      stage_ovf;
    logic      stage_clr;
    logic      brw_set;
    logic      brw_clr;
    bslot_op_e bslot_op;
    logic      len_rd_newest;
    logic      len_rd_bslot;
    logic      idx_clr;
    logic      idx_inc;
    logic      cmp_rd;
    logic      cp_rd;
    logic      cp_wr;
    logic      commit;
    logic      str_rd;
    logic      out_char;
    logic      out_nf;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic browsing;
    logic at_oldest;
    logic nxt_is_ws;
    logic stg_full;
    logic stg_empty;
    logic overlong;
    logic len_eq;
    logic len_zero;
    logic chr_eq;
    logic cmp_last;
    logic str_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/chr_datapath.sv -----
`default_nettype none

module chr_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  chr_pkg::in_item_t   in_data_i,
  input  chr_pkg::dp_cmd_t    cmd_i,
  output chr_pkg::dp_status_t status_o,
  input  wire                 out_ready_i,
  output logic                out_valid_o,
  output chr_pkg::out_item_t  out_data_o
);

  localparam int unsigned SLOT_W = chr_pkg::SLOT_W;
  localparam int unsigned LEN_W  = chr_pkg::LEN_W;
  localparam int unsigned CNT_W  = chr_pkg::CNT_W;
  localparam int unsigned ADDR_W = chr_pkg::ADDR_W;
  localparam int unsigned CW1    = CNT_W + 1;

  logic [7:0]       store_mem [chr_pkg::ENTRIES * chr_pkg::LINE_CHARS];
  logic [LEN_W-1:0] len_mem   [chr_pkg::ENTRIES];
  logic [7:0]       stage_mem [chr_pkg::LINE_CHARS];

  logic [LEN_W-1:0]  stg_len_q, stg_len_d;
  logic              ovl_q, ovl_d;
  logic [SLOT_W-1:0] ws_q, ws_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SLOT_W-1:0] bslot_q, bslot_d;
  logic              brw_q, brw_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  chr_pkg::out_item_t out_q, out_d;

  logic [7:0]       st_rd_q;
  logic [7:0]       stg_rd_q;
  logic [LEN_W-1:0] len_rd_q;

  logic [SLOT_W-1:0] newest, oldest, bslot_inc, bslot_dec, ws_inc;
  logic [CW1-1:0]    ws_ext, cnt_ext, old_w;
  logic [LEN_W-1:0]  idx_nxt;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [SLOT_W-1:0] rd_slot, len_rd_slot;
  logic              out_free;

  assign newest    = (ws_q == '0) ? SLOT_W'(chr_pkg::ENTRIES - 1) : ws_q - SLOT_W'(1);
  assign ws_inc    = (ws_q == SLOT_W'(chr_pkg::ENTRIES - 1)) ? '0 : ws_q + SLOT_W'(1);
  assign bslot_inc = (bslot_q == SLOT_W'(chr_pkg::ENTRIES - 1)) ? '0 : bslot_q + SLOT_W'(1);
  assign bslot_dec = (bslot_q == '0) ? SLOT_W'(chr_pkg::ENTRIES - 1) : bslot_q - SLOT_W'(1);
  assign ws_ext    = CW1'(ws_q);
  assign cnt_ext   = CW1'(cnt_q);
  assign old_w     = (ws_ext >= cnt_ext) ? ws_ext - cnt_ext
                                         : ws_ext + CW1'(chr_pkg::ENTRIES) - cnt_ext;
  assign oldest    = old_w[SLOT_W-1:0];
  assign idx_nxt   = idx_q + LEN_W'(1);
  assign out_free  = !out_valid_q || out_ready_i;

  assign rd_slot     = cmd_i.cmp_rd ? newest : bslot_q;
  assign rd_addr     = ADDR_W'(rd_slot) * ADDR_W'(chr_pkg::LINE_CHARS) + ADDR_W'(idx_q);
  assign wr_addr     = ADDR_W'(ws_q) * ADDR_W'(chr_pkg::LINE_CHARS) + ADDR_W'(idx_q);
  assign len_rd_slot = cmd_i.len_rd_newest ? newest : bslot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cp_wr) begin
      store_mem[wr_addr] <= stg_rd_q;
    end
    if (cmd_i.cmp_rd || cmd_i.str_rd) begin
      st_rd_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_wr) begin
      stage_mem[stg_len_q] <= in_data_i.char_code;
    end
    if (cmd_i.cmp_rd || cmd_i.cp_rd) begin
      stg_rd_q <= stage_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      len_mem[ws_q] <= stg_len_q;
    end
    if (cmd_i.len_rd_newest || cmd_i.len_rd_bslot) begin
      len_rd_q <= len_mem[len_rd_slot];
    end
  end

  always_comb begin
    stg_len_d   = stg_len_q;
    ovl_d       = ovl_q;
    ws_d        = ws_q;
    cnt_d       = cnt_q;
    bslot_d     = bslot_q;
    brw_d       = brw_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (cmd_i.stage_wr) begin
      stg_len_d = stg_len_q + LEN_W'(1);
    end
    if (cmd_i.stage_ovf) begin
      ovl_d = 1'b1;
    end
    if (cmd_i.stage_clr) begin
      stg_len_d = '0;
      ovl_d     = 1'b0;
    end
    if (cmd_i.commit) begin
      ws_d = ws_inc;
      if (cnt_q != CNT_W'(chr_pkg::ENTRIES)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
    if (cmd_i.brw_set) begin
      brw_d = 1'b1;
    end
    if (cmd_i.brw_clr) begin
      brw_d = 1'b0;
    end
    case (cmd_i.bslot_op)
      chr_pkg::BS_HOLD:   bslot_d = bslot_q;
      chr_pkg::BS_NEWEST: bslot_d = newest;
      chr_pkg::BS_DEC:    bslot_d = bslot_dec;
      chr_pkg::BS_INC:    bslot_d = bslot_inc;
      default:            bslot_d = bslot_q;
    endcase
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_nxt;
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_char) begin
      out_valid_d     = 1'b1;
      out_d.out_char  = st_rd_q;
      out_d.found     = 1'b1;
      out_d.last_char = (idx_nxt == len_rd_q);
    end else if (cmd_i.out_nf) begin
      out_valid_d     = 1'b1;
      out_d.out_char  = '0;
      out_d.found     = 1'b0;
      out_d.last_char = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_len_q   <= '0;
      ovl_q       <= 1'b0;
      ws_q        <= '0;
      cnt_q       <= '0;
      bslot_q     <= '0;
      brw_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stg_len_q   <= stg_len_d;
      ovl_q       <= ovl_d;
      ws_q        <= ws_d;
      cnt_q       <= cnt_d;
      bslot_q     <= bslot_d;
      brw_q       <= brw_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.browsing  = brw_q;
  assign status_o.at_oldest = (bslot_q == oldest);
  assign status_o.nxt_is_ws = (bslot_inc == ws_q);
  assign status_o.stg_full  = (stg_len_q == LEN_W'(chr_pkg::MAX_STORED));
  assign status_o.stg_empty = (stg_len_q == '0);
  assign status_o.overlong  = ovl_q;
  assign status_o.len_eq    = (len_rd_q == stg_len_q);
  assign status_o.len_zero  = (len_rd_q == '0);
  assign status_o.chr_eq    = (st_rd_q == stg_rd_q);
  assign status_o.cmp_last  = (idx_nxt == stg_len_q);
  assign status_o.str_last  = (idx_nxt == len_rd_q);
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/chr_ctrl.sv -----
`default_nettype none

module chr_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  chr_pkg::in_item_t   in_data_i,
  input  chr_pkg::dp_status_t status_i,
  output chr_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_COMMIT  = 12'b0000_0000_0010,
    ST_CMP_LEN = 12'b0000_0000_0100,
    ST_CMP_RD  = 12'b0000_0000_1000,
    ST_CMP_CHK = 12'b0000_0001_0000,
    ST_CP_RD   = 12'b0000_0010_0000,
    ST_CP_WR   = 12'b0000_0100_0000,
    ST_BR_LEN  = 12'b0000_1000_0000,
    ST_BR_CHK  = 12'b0001_0000_0000,
    ST_STR_RD  = 12'b0010_0000_0000,
    ST_STR_OUT = 12'b0100_0000_0000,
    ST_NF      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.bslot_op = chr_pkg::BS_HOLD;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.opcode)
            chr_pkg::OP_APPEND: begin
              if (in_data_i.char_code != '0) begin
                if (status_i.stg_full) begin
                  cmd_o.stage_ovf = 1'b1;
                end else begin
                  cmd_o.stage_wr = 1'b1;
                end
              end
              if (in_data_i.line_end) begin
                state_d = ST_COMMIT;
              end
            end
            chr_pkg::OP_OLDER: begin
              if (status_i.cnt_zero) begin
                state_d = ST_NF;
              end else begin
                cmd_o.brw_set = 1'b1;
                if (!status_i.browsing) begin
                  cmd_o.bslot_op = chr_pkg::BS_NEWEST;
                end else if (!status_i.at_oldest) begin
                  cmd_o.bslot_op = chr_pkg::BS_DEC;
                end
                state_d = ST_BR_LEN;
              end
            end
            chr_pkg::OP_NEWER: begin
              if (!status_i.browsing) begin
                state_d = ST_NF;
              end else if (status_i.nxt_is_ws) begin
                cmd_o.brw_clr = 1'b1;
                state_d       = ST_NF;
              end else begin
                cmd_o.bslot_op = chr_pkg::BS_INC;
                state_d        = ST_BR_LEN;
              end
            end
            default: begin
              cmd_o.brw_clr = 1'b1;
            end
          endcase
        end
      end
      ST_COMMIT: begin
        cmd_o.idx_clr = 1'b1;
        if (status_i.stg_empty) begin
          cmd_o.stage_clr = 1'b1;
          state_d         = ST_IDLE;
        end else if (status_i.cnt_zero || status_i.overlong) begin
          state_d = ST_CP_RD;
        end else begin
          cmd_o.len_rd_newest = 1'b1;
          state_d             = ST_CMP_LEN;
        end
      end
      ST_CMP_LEN: begin
        state_d = status_i.len_eq ? ST_CMP_RD : ST_CP_RD;
      end
      ST_CMP_RD: begin
        cmd_o.cmp_rd = 1'b1;
        state_d      = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (!status_i.chr_eq) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_CP_RD;
        end else if (status_i.cmp_last) begin
          cmd_o.stage_clr = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_CMP_RD;
        end
      end
      ST_CP_RD: begin
        cmd_o.cp_rd = 1'b1;
        state_d     = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd_o.cp_wr = 1'b1;
        if (status_i.cmp_last) begin
          cmd_o.commit    = 1'b1;
          cmd_o.stage_clr = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_CP_RD;
        end
      end
      ST_BR_LEN: begin
        cmd_o.len_rd_bslot = 1'b1;
        cmd_o.idx_clr      = 1'b1;
        state_d            = ST_BR_CHK;
      end
      ST_BR_CHK: begin
        state_d = status_i.len_zero ? ST_NF : ST_STR_RD;
      end
      ST_STR_RD: begin
        cmd_o.str_rd = 1'b1;
        state_d      = ST_STR_OUT;
      end
      ST_STR_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_char = 1'b1;
          if (status_i.str_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_STR_RD;
          end
        end
      end
      ST_NF: begin
        if (status_i.out_free) begin
          cmd_o.out_nf = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/command_history_ring_unit.sv -----
// Items are accepted only while idle; the final append item of a line adds a commit made of
// the two-step compare and copy over the line store port.
// Older and newer requests read each character through the store read port, then output
// it once the output register is free, or give a not-found result; stop requests end browsing.
// Asynchronous active-low reset empties the ring, the staged line and the output register.
`default_nettype none

module command_history_ring_unit (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  chr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output chr_pkg::out_item_t out_data_o
);

  chr_pkg::dp_cmd_t    cmd;
  chr_pkg::dp_status_t status;

  chr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  chr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_command_history_ring_unit.sv -----
`default_nettype none

module tb_command_history_ring_unit;

  typedef bit [7:0] byte_q_t[$];
  typedef bit [chr_pkg::SLOT_W-1:0] slot_t;

  class history_scoreboard;
    bit [7:0]                  ring_text [chr_pkg::ENTRIES][chr_pkg::LINE_CHARS];
    bit [chr_pkg::LEN_W-1:0]   ring_len [chr_pkg::ENTRIES];
    bit [7:0]                  draft_text [chr_pkg::LINE_CHARS];
    bit [chr_pkg::LEN_W-1:0]   draft_len;
    bit                        draft_long;
    bit [chr_pkg::SLOT_W-1:0]  next_slot;
    bit [chr_pkg::SLOT_W-1:0]  view_slot;
    bit [chr_pkg::CNT_W-1:0]   stored_lines;
    bit                        viewing;
    chr_pkg::out_item_t        expected_chars[$];
    int                        errors;

    function bit [chr_pkg::SLOT_W-1:0] wrap_slot(int s);
      return slot_t'((s + chr_pkg::ENTRIES) % chr_pkg::ENTRIES);
    endfunction

    function void expect_none_found();
      chr_pkg::out_item_t r;
      r.out_char  = 8'h00;
      r.found     = 1'b0;
      r.last_char = 1'b1;
      expected_chars.push_back(r);
    endfunction

    function void expect_line(bit [chr_pkg::SLOT_W-1:0] slot);
      chr_pkg::out_item_t r;
      int                 n;
      int                 i;
      n = ring_len[slot];
      if (n == 0) begin
        expect_none_found();
        return;
      end
      for (i = 0; i < n; i++) begin
        r.out_char  = ring_text[slot][i];
        r.found     = 1'b1;
        r.last_char = (i == n - 1);
        expected_chars.push_back(r);
      end
    endfunction

    function void note_request(chr_pkg::in_item_t it);
      bit [chr_pkg::SLOT_W-1:0] newest;
      bit [chr_pkg::SLOT_W-1:0] oldest;
      bit                       same;
      int                       i;
      case (chr_pkg::op_e'(it.opcode))
        chr_pkg::OP_APPEND: begin
          if (it.char_code != 8'h00) begin
            if (draft_len < chr_pkg::MAX_STORED) begin
              draft_text[draft_len] = it.char_code;
              draft_len++;
            end else begin
              draft_long = 1'b1;
            end
          end
          if (it.line_end) begin
            newest = wrap_slot(int'(next_slot) - 1);
            same = (stored_lines != 0) && !draft_long && (ring_len[newest] == draft_len);
            for (i = 0; i < draft_len; i++) begin
              if (ring_text[newest][i] != draft_text[i]) same = 1'b0;
            end
            if (draft_len != 0 && !same) begin
              for (i = 0; i < draft_len; i++) ring_text[next_slot][i] = draft_text[i];
              ring_len[next_slot] = draft_len;
              next_slot = wrap_slot(int'(next_slot) + 1);
              if (stored_lines < chr_pkg::ENTRIES) stored_lines++;
            end
            draft_len  = '0;
            draft_long = 1'b0;
          end
        end
        chr_pkg::OP_OLDER: begin
          if (stored_lines == 0) begin
            expect_none_found();
          end else begin
            if (!viewing) begin
              viewing   = 1'b1;
              view_slot = wrap_slot(int'(next_slot) - 1);
            end else begin
              oldest = wrap_slot(int'(next_slot) - int'(stored_lines));
              if (view_slot != oldest) view_slot = wrap_slot(int'(view_slot) - 1);
            end
            expect_line(view_slot);
          end
        end
        chr_pkg::OP_NEWER: begin
          if (!viewing) begin
            expect_none_found();
          end else if (wrap_slot(int'(view_slot) + 1) == next_slot) begin
            viewing = 1'b0;
            expect_none_found();
          end else begin
            view_slot = wrap_slot(int'(view_slot) + 1);
            expect_line(view_slot);
          end
        end
        default: begin
          viewing = 1'b0;
        end
      endcase
    endfunction

    function void check_output(chr_pkg::out_item_t got);
      chr_pkg::out_item_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_char != want.out_char) begin
        errors++;
        $display("%0t: out_char expected %h actual %h", $time, want.out_char, got.out_char);
      end
      if (got.found != want.found) begin
        errors++;
        $display("%0t: found expected %b actual %b", $time, want.found, got.found);
      end
      if (got.last_char != want.last_char) begin
        errors++;
        $display("%0t: last_char expected %b actual %b", $time, want.last_char,
                 got.last_char);
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  chr_pkg::in_item_t  in_data_i   = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  chr_pkg::out_item_t out_data_o;

  history_scoreboard sb;
  int                items_sent;
  int                burst_left;
  bit [7:0]          stall_pattern;
  int                stall_left;

  command_history_ring_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_left    = $urandom_range(20, 120);
      stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
    end
    stall_left--;
    stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
    out_ready_i <= stall_pattern[0];
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_output(out_data_o);
  end

  task automatic send_item(input chr_pkg::op_e op, input bit [7:0] ch, input bit last);
    chr_pkg::in_item_t it;
    it.opcode    = op;
    it.char_code = ch;
    it.line_end  = last;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(it);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_line(input byte_q_t text, input bit zero_close);
    int i;
    for (i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(chr_pkg::op_e'($urandom_range(1, 3)), 8'($urandom()), 1'($urandom()));
      end
      send_item(chr_pkg::OP_APPEND, text[i], !zero_close && (i == text.size() - 1));
    end
    if (zero_close || text.size() == 0) send_item(chr_pkg::OP_APPEND, 8'h00, 1'b1);
  endtask

  initial begin
    int      r;
    int      n;
    int      k;
    byte_q_t text;
    byte_q_t prev_line;
    sb         = new();
    burst_left = $urandom_range(1, 8);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(chr_pkg::OP_OLDER, 8'hFF, 1'b1);
    send_item(chr_pkg::OP_NEWER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_STOP, 8'hAA, 1'b1);
    send_item(chr_pkg::OP_APPEND, 8'h00, 1'b1);
    send_item(chr_pkg::OP_APPEND, 8'h01, 1'b1);
    send_item(chr_pkg::OP_APPEND, 8'hFF, 1'b0);
    send_item(chr_pkg::OP_APPEND, 8'h00, 1'b0);
    send_item(chr_pkg::OP_APPEND, 8'h80, 1'b0);
    send_item(chr_pkg::OP_APPEND, 8'h00, 1'b1);
    send_item(chr_pkg::OP_APPEND, 8'hFF, 1'b0);
    send_item(chr_pkg::OP_APPEND, 8'h80, 1'b1);
    send_item(chr_pkg::OP_APPEND, 8'h7F, 1'b1);
    send_item(chr_pkg::OP_OLDER, 8'h55, 1'b0);
    send_item(chr_pkg::OP_OLDER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_OLDER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_OLDER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_NEWER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_NEWER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_NEWER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_OLDER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_APPEND, 8'h41, 1'b0);
    send_item(chr_pkg::OP_OLDER, 8'h00, 1'b1);
    send_item(chr_pkg::OP_APPEND, 8'h42, 1'b1);
    send_item(chr_pkg::OP_NEWER, 8'h00, 1'b0);
    send_item(chr_pkg::OP_STOP, 8'h00, 1'b0);
    send_item(chr_pkg::OP_NEWER, 8'h00, 1'b0);

    while (items_sent < 440) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 7) == 0) begin
          text = prev_line;
        end else begin
          k = $urandom_range(0, 19);
          n = (k == 0) ? $urandom_range(60, 70) : (k == 1) ? 0 : $urandom_range(1, 8);
          text.delete();
          repeat (n) begin
            text.push_back(($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
          end
        end
        send_line(text, 1'($urandom()));
        prev_line = text;
      end else if (r < 85) begin
        repeat ($urandom_range(1, 20)) begin
          send_item(($urandom_range(0, 9) < 6) ? chr_pkg::OP_OLDER : chr_pkg::OP_NEWER,
                    8'($urandom()), 1'($urandom()));
        end
      end else if (r < 90) begin
        send_item(chr_pkg::OP_STOP, 8'($urandom()), 1'($urandom()));
      end else begin
        send_item(chr_pkg::op_e'($urandom_range(0, 3)), 8'($urandom()), 1'($urandom()));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/chr_pkg.sv
rtl/core/chr_datapath.sv
rtl/core/chr_ctrl.sv
rtl/core/command_history_ring_unit.sv
tb/tb_command_history_ring_unit.sv
